/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants and sequencer state type for the modular exponentiation
// core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_WIDTH_DEF = 31;
    localparam int BASE_W        = 31;
    localparam int EXP_W         = 63;
    localparam int RESULT_W      = 31;
    localparam int CFG_W         = 31;
    localparam int CNT_W         = $clog2(BASE_W);

    localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

endpackage

/* rtl/modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// or base^(modulus-2) mod modulus in inverse mode.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one word of mode,
// base and exponent; the output channel (out_valid/out_ready) returns one
// result word per input word. The modulus is written through cfg_we and
// cfg_data; the user must write it only while the core is idle, as the core
// does not enforce this. Reset loads 1000000007 into the modulus.
// All arithmetic runs on one shift-add modular multiplier that handles one
// multiplier bit per cycle. Sequence: the word is loaded, the base is reduced
// bit by bit, then for every exponent bit up to its highest set bit there is
// a check step, a multiply when the bit is set and then a square; a done step
// returns the result. A modulus below two answers 0 without reducing or
// multiplying.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, and a new word is accepted while it waits. If the
// receiver stalls, the next result waits in the done state until the
// output register is free. Reset clears the sequencer and drops out_valid.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [mexp_pkg::BASE_W-1:0]   base,
    input  logic [mexp_pkg::EXP_W-1:0]    exponent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mexp_pkg::RESULT_W-1:0] result
);

    localparam int W     = MOD_WIDTH;
    localparam int CNT_W = mexp_pkg::CNT_W;
    localparam logic [W-1:0] MOD_RST = mexp_pkg::MODULUS_RESET[W-1:0];

    mexp_pkg::state_t state_reg, state_next;

    logic [W-1:0]                    mod_reg;
    logic [W-1:0]                    acc_reg, acc_next;
    logic [W-1:0]                    b_reg, b_next;
    logic [W-1:0]                    r_reg, r_next;
    logic [mexp_pkg::BASE_W-1:0]     op_reg, op_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [mexp_pkg::EXP_W-1:0]      exp_reg, exp_next;
    logic                            out_valid_reg, out_valid_next;
    logic [mexp_pkg::RESULT_W-1:0]   result_reg, result_next;

    logic                            mod_small;
    logic                            out_free;
    logic                            last_bit;

    // shared modular step unit
    logic [W-1:0]                    step_addend;
    logic                            step_bit;
    logic [W:0]                      dbl;
    logic [W-1:0]                    dbl_red;
    logic [W:0]                      sum;
    logic [W-1:0]                    step_out;

    assign mod_small = (mod_reg < W'(2));
    assign out_free  = !out_valid_reg || out_ready;
    assign last_bit  = (cnt_reg == '0);
    assign step_bit  = op_reg[cnt_reg];

    // r <- 2r + bit*addend mod m, with r and addend below m
    always_comb
    begin
        dbl      = {r_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, mod_reg}) ? W'(dbl - {1'b0, mod_reg}) : dbl[W-1:0];
        sum      = {1'b0, dbl_red} + (step_bit ? {1'b0, step_addend} : '0);
        step_out = (sum >= {1'b0, mod_reg}) ? W'(sum - {1'b0, mod_reg}) : sum[W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (last_bit)
                    state_next = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_CHECK:
            begin
                if (exp_reg == '0)
                    state_next = mexp_pkg::ST_DONE;
                else if (exp_reg[0])
                    state_next = mexp_pkg::ST_MUL;
                else
                    state_next = mexp_pkg::ST_SQR;
            end
            mexp_pkg::ST_MUL:
            begin
                if (last_bit)
                    state_next = mexp_pkg::ST_SQR;
            end
            mexp_pkg::ST_SQR:
            begin
                if (last_bit)
                    state_next = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = mexp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_ready       = 1'b0;
        step_addend    = b_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    acc_next = mod_small ? '0 : W'(1);
                    r_next   = '0;
                    op_next  = base;
                    cnt_next = CNT_W'(mexp_pkg::BASE_W - 1);
                    exp_next = mode ? mexp_pkg::EXP_W'(mod_reg - W'(2)) : exponent;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                // addend of one turns the step into base mod m, one bit a cycle
                step_addend = W'(1);
                r_next      = step_out;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last_bit)
                    b_next = step_out;
            end
            mexp_pkg::ST_CHECK:
            begin
                r_next   = '0;
                op_next  = mexp_pkg::BASE_W'(b_reg);
                cnt_next = CNT_W'(W - 1);
            end
            mexp_pkg::ST_MUL:
            begin
                step_addend = acc_reg;
                r_next      = step_out;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last_bit)
                begin
                    acc_next = step_out;
                    r_next   = '0;
                    op_next  = mexp_pkg::BASE_W'(b_reg);
                    cnt_next = CNT_W'(W - 1);
                end
            end
            mexp_pkg::ST_SQR:
            begin
                step_addend = b_reg;
                r_next      = step_out;
                cnt_next    = cnt_reg - CNT_W'(1);
                if (last_bit)
                begin
                    b_next   = step_out;
                    exp_next = exp_reg >> 1;
                end
            end
            mexp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = mexp_pkg::RESULT_W'(acc_reg);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            mod_reg       <= MOD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                mod_reg <= cfg_data[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // a word taken in idle always starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != mexp_pkg::ST_IDLE))
        else $error("accepted word did not start the sequencer");

    // a modulus below two skips straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mod_small) |=> (state_reg == mexp_pkg::ST_DONE))
        else $error("small modulus did not short-cut");

    // partial product stays reduced while multiplying
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_MUL || state_reg == mexp_pkg::ST_SQR)
        |-> (r_reg < mod_reg))
        else $error("partial product not reduced");

    // operands stay reduced between multiplications
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_CHECK) |-> (acc_reg < mod_reg && b_reg < mod_reg))
        else $error("operand not reduced");

    // a new result only loads once the previous one has left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_DONE && out_valid_reg && !out_ready)
        |=> (state_reg == mexp_pkg::ST_DONE))
        else $error("result overwritten while stalled");

endmodule
